>>> sv/max_pool_argmax_stream_top_assert.svh
// Assertion macros shared by the RTL of the max pooling block.
// Needs a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef MAX_POOL_ARGMAX_STREAM_TOP_ASSERT_SVH
`define MAX_POOL_ARGMAX_STREAM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MPA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define MPA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MPA_ASSERT_ALWAYS(lbl, expr, msg)
`define MPA_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

>>> sv/mpa_pkg.sv
// Package of the max pooling block: constants, register codes and types.
// Used by the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mpa_pkg;

    localparam int MAX_WIDTH_DEF    = 512;
    localparam int MAX_HEIGHT_DEF   = 512;
    localparam int MAX_CHANNELS_DEF = 512;
    localparam int MAX_WINDOW_DEF   = 16;

    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 28;
    localparam int FLAT_W    = 27;
    localparam int CFG_W     = 10;
    localparam int WIN_REG_W = 5;
    localparam int CFG_IDX_W = 2;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;

    localparam logic signed [VALUE_W-1:0] FLOOR_Q16 = 32'shFC19_0000;
    localparam logic signed [INDEX_W-1:0] NO_INDEX  = 28'shFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_HEIGHT   = 2'd0,
        CFG_IN_WIDTH    = 2'd1,
        CFG_CHANNELS    = 2'd2,
        CFG_WINDOW_SIZE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic proc;
        logic first;
        logic close;
        logic last;
    } t_win_flags;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [INDEX_W-1:0] index;
        logic                      image_end;
    } t_result;

endpackage
`default_nettype wire

>>> sv/mpa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read returns the old word when the same address is written in that cycle.
`timescale 1ns / 1ps
`default_nettype none
module mpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/mpa_divider.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the top level to realign the window position counters.
`timescale 1ns / 1ps
`default_nettype none
module mpa_divider #(
    parameter int NW = 9,
    parameter int DW = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_busy,
    output logic      [NW-1:0] o_quotient,
    output logic      [DW-1:0] o_remainder
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          fits;
    logic [NW-1:0] n_quo;
    logic [DW-1:0] n_rem;

    always_comb begin
        rem_sh  = {r_rem, r_quo[NW-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        fits    = rem_sh >= {1'b0, r_div};
        n_rem   = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        n_quo   = (r_quo << 1) | NW'(fits);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(NW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (o_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy      = (r_cnt != '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

>>> sv/max_pool_argmax_stream_top.sv
// Top level of the streaming 2-D max pooling block with argmax.
// Depends on mpa_pkg, mpa_ram, mpa_divider and the assertion macro header.
//
// Usage: pixels enter on i_pixel_value with i_valid/o_ready, one per
// transfer, channel-planar and in raster order, image after image. Each
// completed k x k window gives one result on o_max_value, o_max_index and
// o_image_end with o_valid/i_ready; o_image_end marks the last window of
// an image. Configuration is written through i_cfg_we, i_cfg_index and
// i_cfg_data while the block is idle.
// Throughput is one pixel per cycle while o_ready is high, set by the
// read-modify-write of the column RAM that holds the running best of each
// output column. A result is valid once the window's last pixel has passed
// the update stage and been written into the output queue. A three-entry
// output queue lets input continue while the receiver stalls; o_ready drops
// once the queue and the update stage hold three results.
// After each configuration write the position counters are realigned to the
// new window size by two bit-serial dividers; o_ready stays low until both
// have finished.
// Reset clears the counters, the queue and the registers to their defaults;
// the column RAM is not cleared, since every window starts from the floor.
`timescale 1ns / 1ps
`default_nettype none
`include "max_pool_argmax_stream_top_assert.svh"
module max_pool_argmax_stream_top #(
    parameter int MAX_WIDTH    = mpa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = mpa_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_CHANNELS = mpa_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_WINDOW   = mpa_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [mpa_pkg::VALUE_W-1:0]   i_pixel_value,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed      [mpa_pkg::VALUE_W-1:0]   o_max_value,
    output logic signed      [mpa_pkg::INDEX_W-1:0]   o_max_index,
    output logic                                      o_image_end,
    input  wire logic                                 i_cfg_we,
    input  wire logic        [mpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [mpa_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_CHANNELS + 1);
    localparam int KW    = $clog2(MAX_WINDOW + 1);
    localparam int DIMW  = (WW > HW) ? ((WW > CW) ? WW : CW) : ((HW > CW) ? HW : CW);
    localparam int SUMW  = ((DIMW > KW) ? DIMW : KW) + 2;
    localparam int RAM_W = mpa_pkg::VALUE_W + mpa_pkg::INDEX_W;
    localparam int VW    = mpa_pkg::VALUE_W;
    localparam int IW    = mpa_pkg::INDEX_W;
    localparam int FW    = mpa_pkg::FLAT_W;
    localparam int PW    = mpa_pkg::FIFO_PTR_W;

    // Configuration registers.
    logic [mpa_pkg::CFG_W-1:0]     r_in_height;
    logic [mpa_pkg::CFG_W-1:0]     r_in_width;
    logic [mpa_pkg::CFG_W-1:0]     r_channels;
    logic [mpa_pkg::WIN_REG_W-1:0] r_window_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_height   <= mpa_pkg::CFG_W'(1);
            r_in_width    <= mpa_pkg::CFG_W'(1);
            r_channels    <= mpa_pkg::CFG_W'(1);
            r_window_size <= mpa_pkg::WIN_REG_W'(2);
        end else if (i_cfg_we) begin
            case (mpa_pkg::t_cfg_idx'(i_cfg_index))
                mpa_pkg::CFG_IN_HEIGHT:   r_in_height   <= i_cfg_data;
                mpa_pkg::CFG_IN_WIDTH:    r_in_width    <= i_cfg_data;
                mpa_pkg::CFG_CHANNELS:    r_channels    <= i_cfg_data;
                mpa_pkg::CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[mpa_pkg::WIN_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective dimensions after clamping.
    logic [HW-1:0] h_eff;
    logic [WW-1:0] w_eff;
    logic [CW-1:0] c_eff;
    logic [KW-1:0] k_eff;

    always_comb begin
        if (r_in_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_in_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_in_height);
        end
        if (r_in_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_in_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_in_width);
        end
        if (r_channels == '0) begin
            c_eff = CW'(1);
        end else if (32'(r_channels) > MAX_CHANNELS) begin
            c_eff = CW'(MAX_CHANNELS);
        end else begin
            c_eff = CW'(r_channels);
        end
        if (r_window_size == '0) begin
            k_eff = KW'(1);
        end else if (32'(r_window_size) > MAX_WINDOW) begin
            k_eff = KW'(MAX_WINDOW);
        end else begin
            k_eff = KW'(r_window_size);
        end
        if (SUMW'(k_eff) > SUMW'(h_eff)) begin
            k_eff = KW'(h_eff);
        end
        if (SUMW'(k_eff) > SUMW'(w_eff)) begin
            k_eff = KW'(w_eff);
        end
    end

    // Position state.
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CH_W-1:0]  r_ch, n_ch;
    logic [FW-1:0]    r_flat, n_flat;
    logic [KW-1:0]    r_ck, n_ck;
    logic [KW-1:0]    r_rk, n_rk;
    logic [COL_W-1:0] r_oc, n_oc;
    logic [COL_W-1:0] r_cbase, n_cbase;
    logic [ROW_W-1:0] r_rbase, n_rbase;

    // Realignment after configuration writes.
    logic             r_sync_req;
    logic             r_sync_run;
    logic             sync_idle;
    logic             sync_load;
    logic             col_busy;
    logic             row_busy;
    logic [COL_W-1:0] col_quo;
    logic [KW-1:0]    col_rem;
    logic [KW-1:0]    row_rem;

    mpa_divider #(
        .NW(COL_W),
        .DW(KW)
    ) u_col_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sync_req),
        .i_dividend (r_col),
        .i_divisor  (k_eff),
        .o_busy     (col_busy),
        .o_quotient (col_quo),
        .o_remainder(col_rem)
    );

    mpa_divider #(
        .NW(ROW_W),
        .DW(KW)
    ) u_row_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sync_req),
        .i_dividend (r_row),
        .i_divisor  (k_eff),
        .o_busy     (row_busy),
        .o_quotient (),
        .o_remainder(row_rem)
    );

    assign sync_idle = !r_sync_req && !r_sync_run;
    assign sync_load = r_sync_run && !r_sync_req && !col_busy && !row_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_req <= 1'b0;
            r_sync_run <= 1'b0;
        end else begin
            r_sync_req <= i_cfg_we;
            if (r_sync_req) begin
                r_sync_run <= 1'b1;
            end else if (sync_load) begin
                r_sync_run <= 1'b0;
            end
        end
    end

    // Window decode of the incoming pixel.
    logic                in_acc;
    logic                in_range;
    logic                col_fit;
    logic                row_fit;
    logic                col_lastwin;
    logic                row_lastwin;
    logic                ch_last;
    logic                ck_end;
    logic                rk_end;
    logic [KW-1:0]       k_m1;
    mpa_pkg::t_win_flags s0_flags;

    always_comb begin
        k_m1        = k_eff - 1'b1;
        ck_end      = (r_ck == k_m1);
        rk_end      = (r_rk == k_m1);
        in_range    = (SUMW'(r_col) < SUMW'(w_eff)) && (SUMW'(r_row) < SUMW'(h_eff))
                      && (SUMW'(r_ch) < SUMW'(c_eff));
        col_fit     = (SUMW'(r_cbase) + SUMW'(k_eff)) <= SUMW'(w_eff);
        row_fit     = (SUMW'(r_rbase) + SUMW'(k_eff)) <= SUMW'(h_eff);
        col_lastwin = (SUMW'(r_cbase) + (SUMW'(k_eff) << 1)) > SUMW'(w_eff);
        row_lastwin = (SUMW'(r_rbase) + (SUMW'(k_eff) << 1)) > SUMW'(h_eff);
        ch_last     = (SUMW'(r_ch) + SUMW'(1)) == SUMW'(c_eff);
        s0_flags.proc  = in_range && col_fit && row_fit;
        s0_flags.first = (r_ck == '0) && (r_rk == '0);
        s0_flags.close = ck_end && rk_end;
        s0_flags.last  = ch_last && row_lastwin && col_lastwin;
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_ch    = r_ch;
        n_flat  = r_flat;
        n_ck    = r_ck;
        n_rk    = r_rk;
        n_oc    = r_oc;
        n_cbase = r_cbase;
        n_rbase = r_rbase;
        if (sync_load) begin
            n_ck    = col_rem;
            n_oc    = col_quo;
            n_cbase = r_col - COL_W'(col_rem);
            n_rk    = row_rem;
            n_rbase = r_row - ROW_W'(row_rem);
        end else if (in_acc) begin
            n_flat = r_flat + 1'b1;
            if ((SUMW'(r_col) + SUMW'(1)) >= SUMW'(w_eff)) begin
                n_col   = '0;
                n_ck    = '0;
                n_oc    = '0;
                n_cbase = '0;
                if ((SUMW'(r_row) + SUMW'(1)) >= SUMW'(h_eff)) begin
                    n_row   = '0;
                    n_rk    = '0;
                    n_rbase = '0;
                    if ((SUMW'(r_ch) + SUMW'(1)) >= SUMW'(c_eff)) begin
                        n_ch   = '0;
                        n_flat = '0;
                    end else begin
                        n_ch = r_ch + 1'b1;
                    end
                end else begin
                    n_row = r_row + 1'b1;
                    if (rk_end) begin
                        n_rk    = '0;
                        n_rbase = r_rbase + ROW_W'(k_eff);
                    end else begin
                        n_rk = r_rk + 1'b1;
                    end
                end
            end else begin
                n_col = r_col + 1'b1;
                if (ck_end) begin
                    n_ck    = '0;
                    n_oc    = r_oc + 1'b1;
                    n_cbase = r_cbase + COL_W'(k_eff);
                end else begin
                    n_ck = r_ck + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_ch    <= '0;
            r_flat  <= '0;
            r_ck    <= '0;
            r_rk    <= '0;
            r_oc    <= '0;
            r_cbase <= '0;
            r_rbase <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_ch    <= n_ch;
            r_flat  <= n_flat;
            r_ck    <= n_ck;
            r_rk    <= n_rk;
            r_oc    <= n_oc;
            r_cbase <= n_cbase;
            r_rbase <= n_rbase;
        end
    end

    // Update stage: read-modify-write of the column RAM.
    logic                  r_s1_valid;
    mpa_pkg::t_win_flags   r_s1_flags;
    logic signed [VW-1:0]  r_s1_pixel;
    logic [FW-1:0]         r_s1_flat;
    logic [COL_W-1:0]      r_s1_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_flags <= s0_flags;
            r_s1_pixel <= i_pixel_value;
            r_s1_flat  <= r_flat;
            r_s1_addr  <= r_oc;
        end
    end

    logic [RAM_W-1:0]     ram_rdata;
    logic [RAM_W-1:0]     ram_wdata;
    logic                 r_wb_valid;
    logic [COL_W-1:0]     r_wb_addr;
    logic signed [VW-1:0] r_wb_value;
    logic signed [IW-1:0] r_wb_index;
    logic                 fwd;
    logic signed [VW-1:0] old_val;
    logic signed [IW-1:0] old_idx;
    logic signed [VW-1:0] base_val;
    logic signed [IW-1:0] base_idx;
    logic signed [VW-1:0] new_val;
    logic signed [IW-1:0] new_idx;
    logic                 wr_en;
    logic                 s1_push;

    always_comb begin
        fwd      = r_wb_valid && (r_wb_addr == r_s1_addr);
        old_val  = fwd ? r_wb_value : ram_rdata[RAM_W-1:IW];
        old_idx  = fwd ? r_wb_index : ram_rdata[IW-1:0];
        base_val = r_s1_flags.first ? mpa_pkg::FLOOR_Q16 : old_val;
        base_idx = r_s1_flags.first ? mpa_pkg::NO_INDEX : old_idx;
        if (r_s1_pixel > base_val) begin
            new_val = r_s1_pixel;
            new_idx = {1'b0, r_s1_flat};
        end else begin
            new_val = base_val;
            new_idx = base_idx;
        end
        wr_en     = r_s1_valid && r_s1_flags.proc;
        s1_push   = wr_en && r_s1_flags.close;
        ram_wdata = {new_val, new_idx};
    end

    mpa_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_WIDTH)
    ) u_col_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_s1_addr),
        .i_wdata(ram_wdata),
        .i_re   (in_acc),
        .i_raddr(r_oc),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else begin
            r_wb_valid <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wb_addr  <= r_s1_addr;
            r_wb_value <= new_val;
            r_wb_index <= new_idx;
        end
    end

    // Output queue.
    mpa_pkg::t_result r_fifo [mpa_pkg::FIFO_DEPTH];
    mpa_pkg::t_result push_data;
    logic [PW-1:0]    r_head;
    logic [PW-1:0]    r_tail;
    logic [PW-1:0]    r_count;
    logic             out_pop;

    assign push_data.value     = new_val;
    assign push_data.index     = new_idx;
    assign push_data.image_end = r_s1_flags.last;

    assign o_valid     = (r_count != '0);
    assign out_pop     = o_valid && i_ready;
    assign o_max_value = r_fifo[r_head].value;
    assign o_max_index = r_fifo[r_head].index;
    assign o_image_end = r_fifo[r_head].image_end;

    assign o_ready = sync_idle
                     && ((3'(r_count) + 3'(s1_push)) < 3'(mpa_pkg::FIFO_DEPTH));
    assign in_acc  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (s1_push) begin
                r_tail <= (r_tail == PW'(mpa_pkg::FIFO_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (out_pop) begin
                r_head <= (r_head == PW'(mpa_pkg::FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (s1_push && !out_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!s1_push && out_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_push) begin
            r_fifo[r_tail] <= push_data;
        end
    end

    `MPA_ASSERT_ALWAYS(a_fifo_bound, 32'(r_count) <= mpa_pkg::FIFO_DEPTH, "queue overfilled")
    `MPA_ASSERT_IMPL(a_push_room, s1_push, (32'(r_count) < mpa_pkg::FIFO_DEPTH) || out_pop, "result pushed into a full queue")
    `MPA_ASSERT_IMPL(a_col_align, sync_idle, (SUMW'(r_cbase) + SUMW'(r_ck)) == SUMW'(r_col), "column window base out of step")
    `MPA_ASSERT_IMPL(a_row_align, sync_idle, (SUMW'(r_rbase) + SUMW'(r_rk)) == SUMW'(r_row), "row window base out of step")
    `MPA_ASSERT_IMPL(a_rem_bound, sync_idle, (r_ck < k_eff) && (r_rk < k_eff), "window offset beyond window size")

endmodule
`default_nettype wire
